[sv/idsd_pkg.sv]
// shared constants and sequencer state type for the incremental dag shortest distance block
package idsd_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = 6;
  localparam int DIST_W    = 6;
  localparam int CNT_W     = 7;
  localparam int MIN_NODES = 3;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROAD_RD,
    ST_ROAD_WR,
    ST_NODE_RD,
    ST_NODE_LD,
    ST_SCAN,
    ST_LAST,
    ST_FIN_RD,
    ST_OUT
  } state_t;

endpackage

[sv/incremental_dag_shortest_distance.sv]
// incremental shortest distance over a chain graph with added forward roads
//
//   channel   dir   payload                                       transaction
//   s_axis    in    tdata: from_node [5:0], to_node [11:6]        tvalid & tready
//   m_axis    out   tdata: distance [5:0]; tuser: bad_road [0]    tvalid & tready
//   cfg       in    cfg_wr_data: node_count [6:0]                 cfg_wr_en
//
// a rejected road skips relaxation: only the final read and output steps come before m_axis_tvalid rises
// an added road to node t first relaxes each node from t up to n-1 in turn before the result,
// using one shared add and compare unit stepping over one distance memory read each cycle
// s_axis_tready is high only while the sequencer idles; a stalled result holds the sequencer
// rst is synchronous: distances read as their node index and all roads as absent at once
module incremental_dag_shortest_distance (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [idsd_pkg::IN_W-1:0]     s_axis_tdata,  // from_node, to_node, zero pad
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [idsd_pkg::OUT_W-1:0]    m_axis_tdata,  // distance, zero pad
  output logic [0:0]                    m_axis_tuser,  // bad_road
  input  logic                          cfg_wr_en,
  input  logic [idsd_pkg::CNT_W-1:0]    cfg_wr_data    // node_count
);

  localparam int NW = idsd_pkg::NODE_W;
  localparam int DW = idsd_pkg::DIST_W;
  localparam int CW = idsd_pkg::CNT_W;
  localparam int MN = idsd_pkg::MAX_NODES;

  idsd_pkg::state_t state, state_next;

  logic [CW-1:0] node_count;
  logic [NW-1:0] src, dst, last, i, l;
  logic [DW-1:0] d;
  logic [MN-1:0] row_reg;
  logic          cmp_en;
  logic          bad;
  logic [DW-1:0] out_dist;
  logic          out_bad;

  // memories
  logic [DW-1:0] bd_mem [MN];
  logic [MN-1:0] bd_valid;
  logic [DW-1:0] bd_rd;
  logic          bd_rd_vld;
  logic [NW-1:0] bd_rd_idx;
  logic [MN-1:0] row_mem [MN];
  logic [MN-1:0] row_valid;
  logic [MN-1:0] row_rd;
  logic          row_rd_vld;

  // control
  logic [NW-1:0] bd_raddr, row_raddr;
  logic          bd_we, row_we;
  logic [DW-1:0] bd_wdata;
  logic [MN-1:0] row_wdata;
  logic          out_fire;

  logic [NW-1:0] in_from, in_to;
  logic [CW-1:0] n_eff;
  logic [NW-1:0] n_last;
  logic          in_bad;
  logic [DW-1:0] bd_val;
  logic [MN-1:0] row_val;
  logic [DW:0]   cand;
  logic [DW-1:0] d_next;
  logic [NW-1:0] i_prev;

  assign in_from = s_axis_tdata[NW-1:0];
  assign in_to   = s_axis_tdata[2*NW-1:NW];

  always_comb begin
    if (node_count < CW'(idsd_pkg::MIN_NODES)) begin
      n_eff = CW'(idsd_pkg::MIN_NODES);
    end else if (node_count > CW'(MN)) begin
      n_eff = CW'(MN);
    end else begin
      n_eff = node_count;
    end
  end

  assign n_last = NW'(n_eff - CW'(1));
  assign in_bad = (in_from >= in_to) || (in_to > n_last);

  assign bd_val  = bd_rd_vld ? bd_rd : DW'(bd_rd_idx);
  assign row_val = row_rd_vld ? row_rd : '0;
  assign i_prev  = i - NW'(1);

  // shared add and compare unit
  assign cand = {1'b0, bd_val} + (DW+1)'(1);
  always_comb begin
    d_next = d;
    if (cmp_en && (cand < {1'b0, d})) begin
      d_next = cand[DW-1:0];
    end
  end

  assign out_fire = !m_axis_tvalid || m_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      idsd_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = in_bad ? idsd_pkg::ST_FIN_RD : idsd_pkg::ST_ROAD_RD;
        end
      end
      idsd_pkg::ST_ROAD_RD: state_next = idsd_pkg::ST_ROAD_WR;
      idsd_pkg::ST_ROAD_WR: state_next = idsd_pkg::ST_NODE_RD;
      idsd_pkg::ST_NODE_RD: state_next = idsd_pkg::ST_NODE_LD;
      idsd_pkg::ST_NODE_LD: state_next = idsd_pkg::ST_SCAN;
      idsd_pkg::ST_SCAN: begin
        if (l == i_prev) begin
          state_next = idsd_pkg::ST_LAST;
        end
      end
      idsd_pkg::ST_LAST: begin
        state_next = (i == last) ? idsd_pkg::ST_FIN_RD : idsd_pkg::ST_NODE_RD;
      end
      idsd_pkg::ST_FIN_RD: state_next = idsd_pkg::ST_OUT;
      idsd_pkg::ST_OUT: begin
        if (out_fire) begin
          state_next = idsd_pkg::ST_IDLE;
        end
      end
      default: state_next = idsd_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    bd_raddr      = last;
    row_raddr     = i;
    bd_we         = 1'b0;
    row_we        = 1'b0;
    bd_wdata      = d_next;
    row_wdata     = row_val | (MN'(1) << src);
    unique case (state)
      idsd_pkg::ST_IDLE:    s_axis_tready = 1'b1;
      idsd_pkg::ST_ROAD_RD: row_raddr = dst;
      idsd_pkg::ST_ROAD_WR: row_we = 1'b1;
      idsd_pkg::ST_NODE_RD: bd_raddr = i;
      idsd_pkg::ST_NODE_LD: bd_raddr = i;
      idsd_pkg::ST_SCAN:    bd_raddr = l;
      idsd_pkg::ST_LAST:    bd_we = 1'b1;
      idsd_pkg::ST_FIN_RD:  bd_raddr = last;
      idsd_pkg::ST_OUT:     bd_raddr = last;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= idsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CW'(MN);
    end else if (cfg_wr_en) begin
      node_count <= cfg_wr_data;
    end
  end

  // distance memory
  always_ff @(posedge clk) begin
    if (bd_we) begin
      bd_mem[i] <= bd_wdata;
    end
    bd_rd     <= bd_mem[bd_raddr];
    bd_rd_idx <= bd_raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bd_valid  <= '0;
      bd_rd_vld <= 1'b0;
    end else begin
      if (bd_we) begin
        bd_valid[i] <= 1'b1;
      end
      bd_rd_vld <= bd_valid[bd_raddr] && !(bd_we && (bd_raddr == i));
    end
  end

  // road memory, one row of source bits per destination node
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[dst] <= row_wdata;
    end
    row_rd <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      row_rd_vld <= 1'b0;
    end else begin
      if (row_we) begin
        row_valid[dst] <= 1'b1;
      end
      row_rd_vld <= row_valid[row_raddr] && !(row_we && (row_raddr == dst));
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      idsd_pkg::ST_IDLE: begin
        src  <= in_from;
        dst  <= in_to;
        last <= n_last;
        bad  <= in_bad;
        i    <= in_to;
      end
      idsd_pkg::ST_NODE_LD: begin
        d       <= bd_val;
        row_reg <= row_val;
        l       <= '0;
        cmp_en  <= 1'b0;
      end
      idsd_pkg::ST_SCAN: begin
        d      <= d_next;
        cmp_en <= row_reg[l] || (l == i_prev);
        l      <= l + NW'(1);
      end
      idsd_pkg::ST_LAST: begin
        i <= i + NW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == idsd_pkg::ST_OUT && out_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == idsd_pkg::ST_OUT && out_fire) begin
      out_dist <= bd_val;
      out_bad  <= bad;
    end
  end

  assign m_axis_tdata = {(idsd_pkg::OUT_W - DW)'(0), out_dist};
  assign m_axis_tuser = out_bad;

`ifndef SYNTHESIS
  a_scan_below_node: assert property (@(posedge clk) disable iff (rst)
    (state == idsd_pkg::ST_SCAN) |-> (l < i))
    else $error("scan index reached the node being relaxed");

  a_node_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == idsd_pkg::ST_LAST) |-> (i <= last))
    else $error("relaxation past the last node");

  a_dist_no_rise: assert property (@(posedge clk) disable iff (rst)
    (state == idsd_pkg::ST_SCAN && $past(state) == idsd_pkg::ST_SCAN) |-> (d <= $past(d)))
    else $error("relaxed distance increased");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == idsd_pkg::ST_OUT))
    else $error("result raised outside the output step");
`endif

endmodule

[tb/idsd_distance_checker.sv]
// checker for the incremental dag shortest distance block: predicts and compares every result
module idsd_distance_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [idsd_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [idsd_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic [0:0]                 m_axis_tuser,
  input  logic                       cfg_wr_en,
  input  logic [idsd_pkg::CNT_W-1:0] cfg_wr_data,
  output int                         errors,
  output int                         pending,
  output int                         roads_added,
  output int                         roads_rejected,
  output int                         results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [idsd_pkg::DIST_W-1:0] distance;
    logic                        bad_road;
  } dist_result_t;

  logic [idsd_pkg::DIST_W-1:0]    best_hops [idsd_pkg::MAX_NODES];
  logic [idsd_pkg::MAX_NODES-1:0] road_in   [idsd_pkg::MAX_NODES];
  logic [idsd_pkg::CNT_W-1:0]     node_limit;
  dist_result_t                   expected_dist [$];

  function automatic int active_nodes();
    if (node_limit < idsd_pkg::MIN_NODES) return idsd_pkg::MIN_NODES;
    if (node_limit > idsd_pkg::MAX_NODES) return idsd_pkg::MAX_NODES;
    return int'(node_limit);
  endfunction

  function automatic dist_result_t add_road(input logic [idsd_pkg::NODE_W-1:0] src, dst);
    int           n;
    int           d;
    dist_result_t r;
    n = active_nodes();
    r.bad_road = (src >= dst) || (int'(dst) >= n);
    if (!r.bad_road) begin
      road_in[dst][src] = 1'b1;
      for (int i = int'(dst); i < n; i++) begin
        d = best_hops[i];
        if (int'(best_hops[i-1]) + 1 < d) d = int'(best_hops[i-1]) + 1;
        for (int l = 0; l < n; l++) begin
          if (road_in[i][l] && int'(best_hops[l]) + 1 < d) d = int'(best_hops[l]) + 1;
        end
        best_hops[i] = d[idsd_pkg::DIST_W-1:0];
      end
    end
    r.distance = best_hops[n-1];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    dist_result_t got;
    dist_result_t want;
    if (rst) begin
      for (int i = 0; i < idsd_pkg::MAX_NODES; i++) begin
        best_hops[i] = i[idsd_pkg::DIST_W-1:0];
        road_in[i]   = '0;
      end
      node_limit = idsd_pkg::CNT_W'(idsd_pkg::MAX_NODES);
      expected_dist.delete();
      errors          = 0;
      roads_added     = 0;
      roads_rejected  = 0;
      results_checked = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.distance = m_axis_tdata[idsd_pkg::DIST_W-1:0];
        got.bad_road = m_axis_tuser[0];
        if (expected_dist.size() == 0) begin
          $error("result transaction with nothing expected: distance %0d bad_road %0d",
                 got.distance, got.bad_road);
          errors++;
        end else begin
          want = expected_dist.pop_front();
          results_checked++;
          if (got.distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, got.distance);
            errors++;
          end
          if (got.bad_road !== want.bad_road) begin
            $error("bad_road: expected %0d, actual %0d", want.bad_road, got.bad_road);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = add_road(s_axis_tdata[idsd_pkg::NODE_W-1:0],
                        s_axis_tdata[2*idsd_pkg::NODE_W-1:idsd_pkg::NODE_W]);
        if (want.bad_road) roads_rejected++;
        else roads_added++;
        expected_dist.insert(expected_dist.size(), want);
      end
      if (cfg_wr_en) node_limit = cfg_wr_data;
    end
    pending = expected_dist.size();
  end

endmodule

[tb/tb_incremental_dag_shortest_distance.sv]
// testbench top for the incremental dag shortest distance block: stimulus, watchdog and verdict
module tb_incremental_dag_shortest_distance;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic                          clk;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [idsd_pkg::IN_W-1:0]     s_axis_tdata;   // from_node, to_node, zero pad
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [idsd_pkg::OUT_W-1:0]    m_axis_tdata;   // distance, zero pad
  logic [0:0]                    m_axis_tuser;   // bad_road
  logic                          cfg_wr_en;
  logic [idsd_pkg::CNT_W-1:0]    cfg_wr_data;

  int   errors;
  int   pending;
  int   roads_added;
  int   roads_rejected;
  int   results_checked;
  int   settings_used;
  int   stall_cycles;
  int   cur_nodes;
  logic idle_on;

  incremental_dag_shortest_distance u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  idsd_distance_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .errors          (errors),
    .pending         (pending),
    .roads_added     (roads_added),
    .roads_rejected  (roads_rejected),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side backpressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready = !(idle_on && $urandom_range(0, 99) < 8);
    end
  end

  // no transaction for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $error("watchdog: no transaction for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_road(input int from_node, input int to_node);
    while (idle_on && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {{(idsd_pkg::IN_W - 2*idsd_pkg::NODE_W){1'b0}},
                     idsd_pkg::NODE_W'(to_node), idsd_pkg::NODE_W'(from_node)};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic set_node_count(input int value);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = idsd_pkg::CNT_W'(value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cur_nodes = (value < idsd_pkg::MIN_NODES) ? idsd_pkg::MIN_NODES :
                (value > idsd_pkg::MAX_NODES) ? idsd_pkg::MAX_NODES : value;
    settings_used++;
  endtask

  // mostly forward roads inside the graph, the rest past the end, backward or noise
  task automatic road_burst(input int count);
    int pick;
    int from_node;
    int to_node;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        from_node = $urandom_range(0, cur_nodes - 2);
        to_node   = $urandom_range(from_node + 1, cur_nodes - 1);
      end else if (pick < 82 && cur_nodes < idsd_pkg::MAX_NODES) begin
        from_node = $urandom_range(0, cur_nodes - 1);
        to_node   = $urandom_range(cur_nodes, idsd_pkg::MAX_NODES - 1);
      end else if (pick < 90) begin
        to_node   = $urandom_range(0, idsd_pkg::MAX_NODES - 1);
        from_node = $urandom_range(to_node, idsd_pkg::MAX_NODES - 1);
      end else begin
        from_node = $urandom_range(0, idsd_pkg::MAX_NODES - 1);
        to_node   = $urandom_range(0, idsd_pkg::MAX_NODES - 1);
      end
      send_road(from_node, to_node);
    end
  endtask

  initial begin
    int phase_nodes [14];
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    idle_on       = 1'b1;
    settings_used = 0;
    cur_nodes     = idsd_pkg::MAX_NODES;
    phase_nodes   = '{3, 8, 2, 12, 65, 5, 20, 1, 40, 6, 127, 16, 64, 9};
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // full size graph after reset
    send_road(0, 63);
    send_road(5, 5);
    send_road(63, 0);
    send_road(63, 63);
    send_road(0, 0);
    send_road(10, 3);
    send_road(0, 63);
    send_road(0, 1);
    send_road(62, 63);
    send_road(1, 62);

    // shrunk graph, roads inside it, backward and past the last node
    set_node_count(10);
    send_road(3, 12);
    send_road(0, 9);
    send_road(9, 10);
    send_road(42, 21);
    send_road(4, 8);

    // below the minimum clamps to three nodes
    set_node_count(0);
    send_road(0, 2);
    send_road(1, 3);
    send_road(0, 1);
    send_road(1, 2);

    // above the maximum clamps to the full graph
    set_node_count(127);
    send_road(20, 40);
    send_road(0, 20);

    for (int p = 0; p < 14; p++) begin
      set_node_count(phase_nodes[p]);
      idle_on = (p != 6);
      road_burst(9);
    end
    idle_on = 1'b1;

    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d results: %0d roads added, %0d roads rejected",
             results_checked, roads_added, roads_rejected);
    $display("went through %0d node count settings, clamped ones included", settings_used);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
